>>> src/bsc_pkg.sv
// Package for the banker's algorithm safety checker.
// Holds the request and result types, mode and register codes, the controller
// state type and the command and status groups. No dependencies.
`timescale 1ns / 1ps

package bsc_pkg;

    localparam int COUNT_W = 5;   // width of process and resource counts
    localparam int PROC_W  = 4;   // width of a process number

    localparam logic [1:0] MODE_LOAD_ALLOC = 2'd0;
    localparam logic [1:0] MODE_LOAD_CLAIM = 2'd1;
    localparam logic [1:0] MODE_LOAD_FREE  = 2'd2;
    localparam logic [1:0] MODE_RUN        = 2'd3;

    localparam int          CFG_INDEX_W        = 1;
    localparam int          CFG_DATA_W         = 5;
    localparam logic [0:0]  REG_PROCESS_COUNT  = 1'd0;
    localparam logic [0:0]  REG_RESOURCE_COUNT = 1'd1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  process_index;
        logic [3:0]  resource_index;
        logic [15:0] amount;
    } in_item_t;

    typedef struct packed {
        logic        is_verdict;
        logic [3:0]  process_number;
        logic        safe;
        logic        last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RD_CHK,
        ST_CMP,
        ST_RD_ADD,
        ST_ADD,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic start;         // clear flags, found count and process counter
        logic restart;       // begin another sweep
        logic skip;          // move to the next process
        logic res_first;     // resource counter to zero
        logic res_next;      // resource counter up by one
        logic mem_rd;        // read allocation and claim at (process, resource)
        logic add;           // add allocation back into the free count
        logic commit;        // record the current process as finished
        logic emit_start;    // rewind the process counter for output
        logic emit_entry;    // load one order entry into the output register
        logic emit_verdict;  // load the verdict into the output register
    } bsc_cmd_t;

    typedef struct packed {
        logic run_req;       // a run request waits at the input
        logic sweep_end;     // process counter has passed the last process
        logic all_found;     // every process in use is finished
        logic progress;      // this sweep finished at least one process
        logic proc_done;     // current process is already finished
        logic fits;          // need does not exceed free for current resource
        logic res_last;      // current resource is the last one in use
        logic entries_left;  // order entries remain to be sent
        logic out_free;      // output register can take a result this cycle
    } bsc_status_t;

endpackage

>>> src/bsc_ctrl.sv
// Controller for the safety checker: sequences sweeps, compares, add-backs and
// result output by driving commands into the datapath. Depends on bsc_pkg.
`timescale 1ns / 1ps

module bsc_ctrl
    import bsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  bsc_status_t status,
    output bsc_cmd_t    cmd,
    output logic        in_ready
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (status.run_req)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.sweep_end)
                begin
                    if (status.all_found || !status.progress)
                    begin
                        state_next = ST_EMIT;
                    end
                end
                else if (!status.proc_done)
                begin
                    state_next = ST_RD_CHK;
                end
            end
            ST_RD_CHK:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (!status.fits)
                begin
                    state_next = ST_SCAN;
                end
                else if (status.res_last)
                begin
                    state_next = ST_RD_ADD;
                end
                else
                begin
                    state_next = ST_RD_CHK;
                end
            end
            ST_RD_ADD:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (status.res_last)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_RD_ADD;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free && !(status.all_found && status.entries_left))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = status.run_req;
            end
            ST_SCAN:
            begin
                if (status.sweep_end)
                begin
                    if (status.all_found || !status.progress)
                    begin
                        cmd.emit_start = 1'b1;
                    end
                    else
                    begin
                        cmd.restart = 1'b1;
                    end
                end
                else if (status.proc_done)
                begin
                    cmd.skip = 1'b1;
                end
                else
                begin
                    cmd.res_first = 1'b1;
                end
            end
            ST_RD_CHK:
            begin
                cmd.mem_rd = 1'b1;
            end
            ST_CMP:
            begin
                if (!status.fits)
                begin
                    cmd.skip = 1'b1;
                end
                else if (status.res_last)
                begin
                    cmd.res_first = 1'b1;
                end
                else
                begin
                    cmd.res_next = 1'b1;
                end
            end
            ST_RD_ADD:
            begin
                cmd.mem_rd = 1'b1;
            end
            ST_ADD:
            begin
                cmd.add = 1'b1;
                if (status.res_last)
                begin
                    cmd.commit = 1'b1;
                end
                else
                begin
                    cmd.res_next = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    if (status.all_found && status.entries_left)
                    begin
                        cmd.emit_entry = 1'b1;
                    end
                    else
                    begin
                        cmd.emit_verdict = 1'b1;
                    end
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> src/bsc_datapath.sv
// Datapath for the safety checker: configuration registers, allocation and
// claim memories, free counts, finished flags, order store and output register.
// Depends on bsc_pkg.
`timescale 1ns / 1ps

module bsc_datapath
    import bsc_pkg::*;
#(
    parameter int MAX_PROCS   = 16,
    parameter int MAX_RES     = 16,
    parameter int AMOUNT_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_accept,
    input  in_item_t               in_data,
    input  logic                   out_ready,
    output logic                   out_valid,
    output out_item_t              out_data,
    input  bsc_cmd_t               cmd,
    output bsc_status_t            status
);

    localparam int PROC_LIMIT = (MAX_PROCS < 16) ? MAX_PROCS : 16;
    localparam int OIDX_W     = $clog2(PROC_LIMIT);
    localparam int RES_W      = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
    localparam int NR_W       = $clog2(MAX_RES + 1);
    localparam int MEM_DEPTH  = MAX_PROCS * MAX_RES;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int FREE_W     = AMOUNT_BITS + 5;

    // Configuration registers.
    logic [COUNT_W-1:0] process_count_reg;
    logic [COUNT_W-1:0] resource_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            process_count_reg  <= COUNT_W'(1);
            resource_count_reg <= COUNT_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PROCESS_COUNT:  process_count_reg  <= cfg_data;
                REG_RESOURCE_COUNT: resource_count_reg <= cfg_data;
                default:            process_count_reg  <= process_count_reg;
            endcase
        end
    end

    // Counts in use, clamped to the supported range.
    logic [COUNT_W-1:0] np;
    logic [NR_W-1:0]    nr;

    always_comb
    begin
        if (process_count_reg == '0)
        begin
            np = COUNT_W'(1);
        end
        else if (process_count_reg > COUNT_W'(PROC_LIMIT))
        begin
            np = COUNT_W'(PROC_LIMIT);
        end
        else
        begin
            np = process_count_reg;
        end

        if (resource_count_reg == '0)
        begin
            nr = NR_W'(1);
        end
        else if (6'(resource_count_reg) > 6'(MAX_RES))
        begin
            nr = NR_W'(MAX_RES);
        end
        else
        begin
            nr = NR_W'(resource_count_reg);
        end
    end

    // Run counters and flags.
    logic [COUNT_W-1:0]    proc_reg;
    logic [RES_W-1:0]      res_reg;
    logic [COUNT_W-1:0]    found_reg;
    logic                  progress_reg;
    logic [PROC_LIMIT-1:0] finished_reg;
    logic [PROC_W-1:0]     order_reg [PROC_LIMIT];

    logic [OIDX_W-1:0] proc_idx;
    logic [OIDX_W-1:0] found_idx;

    assign proc_idx  = OIDX_W'(proc_reg);
    assign found_idx = OIDX_W'(found_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proc_reg     <= '0;
            res_reg      <= '0;
            found_reg    <= '0;
            progress_reg <= 1'b0;
            finished_reg <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                proc_reg     <= '0;
                found_reg    <= '0;
                progress_reg <= 1'b0;
                finished_reg <= '0;
            end
            if (cmd.restart || cmd.emit_start)
            begin
                proc_reg     <= '0;
                progress_reg <= 1'b0;
            end
            if (cmd.skip || cmd.emit_entry)
            begin
                proc_reg <= proc_reg + COUNT_W'(1);
            end
            if (cmd.res_first)
            begin
                res_reg <= '0;
            end
            if (cmd.res_next)
            begin
                res_reg <= res_reg + RES_W'(1);
            end
            if (cmd.commit)
            begin
                finished_reg[proc_idx] <= 1'b1;
                found_reg              <= found_reg + COUNT_W'(1);
                progress_reg           <= 1'b1;
                proc_reg               <= proc_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            order_reg[found_idx] <= PROC_W'(proc_reg);
        end
    end

    // Allocation and claim memories, one write port for loads and one
    // registered read port for the sweep.
    logic [AMOUNT_BITS-1:0] alloc_mem [MEM_DEPTH];
    logic [AMOUNT_BITS-1:0] claim_mem [MEM_DEPTH];
    logic [AMOUNT_BITS-1:0] alloc_q;
    logic [AMOUNT_BITS-1:0] claim_q;
    logic [ADDR_W-1:0]      wr_addr;
    logic [ADDR_W-1:0]      rd_addr;
    logic [AMOUNT_BITS-1:0] load_amount;
    logic                   load_req;
    logic                   proc_ok;
    logic                   res_ok;

    assign load_req    = in_accept && (in_data.mode != MODE_RUN);
    assign proc_ok     = int'(in_data.process_index) < MAX_PROCS;
    assign res_ok      = int'(in_data.resource_index) < MAX_RES;
    assign load_amount = AMOUNT_BITS'(in_data.amount);
    assign wr_addr     = ADDR_W'(int'(in_data.process_index) * MAX_RES
                                 + int'(in_data.resource_index));
    assign rd_addr     = ADDR_W'(int'(proc_reg) * MAX_RES + int'(res_reg));

    always_ff @(posedge clk)
    begin
        if (load_req && res_ok && proc_ok && (in_data.mode == MODE_LOAD_ALLOC))
        begin
            alloc_mem[wr_addr] <= load_amount;
        end
        if (load_req && res_ok && proc_ok && (in_data.mode == MODE_LOAD_CLAIM))
        begin
            claim_mem[wr_addr] <= load_amount;
        end
        if (cmd.mem_rd)
        begin
            alloc_q <= alloc_mem[rd_addr];
            claim_q <= claim_mem[rd_addr];
        end
    end

    // Free counts, updated in place by loads and by add-backs.
    logic [FREE_W-1:0]      free_reg [MAX_RES];
    logic [FREE_W-1:0]      free_cur;
    logic [AMOUNT_BITS:0]   need;
    logic [FREE_W:0]        sum;
    logic [FREE_W-1:0]      sum_sat;

    assign free_cur = free_reg[res_reg];
    assign need     = {1'b0, claim_q} - {1'b0, alloc_q};
    assign sum      = {1'b0, free_cur} + (FREE_W + 1)'(alloc_q);
    assign sum_sat  = sum[FREE_W] ? '1 : sum[FREE_W-1:0];

    always_ff @(posedge clk)
    begin
        if (load_req && res_ok && (in_data.mode == MODE_LOAD_FREE))
        begin
            free_reg[RES_W'(in_data.resource_index)] <= FREE_W'(load_amount);
        end
        else if (cmd.add)
        begin
            free_reg[res_reg] <= sum_sat;
        end
    end

    // Output register.
    logic      out_valid_reg;
    out_item_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_entry || cmd.emit_verdict)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_entry)
        begin
            out_data_reg.is_verdict     <= 1'b0;
            out_data_reg.process_number <= order_reg[proc_idx];
            out_data_reg.safe           <= 1'b1;
            out_data_reg.last           <= 1'b0;
        end
        else if (cmd.emit_verdict)
        begin
            out_data_reg.is_verdict     <= 1'b1;
            out_data_reg.process_number <= '0;
            out_data_reg.safe           <= (found_reg == np);
            out_data_reg.last           <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A negative need always fits.
    always_comb
    begin
        status.run_req      = in_valid && (in_data.mode == MODE_RUN);
        status.sweep_end    = (proc_reg == np);
        status.all_found    = (found_reg == np);
        status.progress     = progress_reg;
        status.proc_done    = finished_reg[proc_idx];
        status.fits         = need[AMOUNT_BITS]
                              || (FREE_W'(need[AMOUNT_BITS-1:0]) <= free_cur);
        status.res_last     = (NR_W'(res_reg) == (nr - NR_W'(1)));
        status.entries_left = (proc_reg != found_reg);
        status.out_free     = !out_valid_reg || out_ready;
    end

endmodule

>>> src/bankers_safety_check.sv
// Banker's algorithm safety checker. Load requests are taken one per cycle while idle.
// A run holds in_ready low: a sweep visits each process, compares each resource of an
// unfinished one and, if all fit, adds each back (one memory read port); at most
// process_count sweeps, then one result per cycle the sink accepts: order if safe,
// then verdict. Reset clears control state and sets both counts to one; the tables,
// free counts and order store stay undefined until loaded, with no clearing pass.
`timescale 1ns / 1ps

module bankers_safety_check
    import bsc_pkg::*;
#(
    parameter int MAX_PROCS   = 16,
    parameter int MAX_RES     = 16,
    parameter int AMOUNT_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_data
);

    bsc_cmd_t    cmd;
    bsc_status_t status;
    logic        in_accept;

    assign in_accept = in_valid && in_ready;

    bsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .status   (status),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    bsc_datapath #(
        .MAX_PROCS   (MAX_PROCS),
        .MAX_RES     (MAX_RES),
        .AMOUNT_BITS (AMOUNT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_accept (in_accept),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

    // A run request blocks further requests on the next cycle.
    a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (in_data.mode == MODE_RUN)) |=> !in_ready)
        else $error("input still ready after a run request");

    // Only the verdict closes a run.
    a_last_is_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.last == out_data.is_verdict))
        else $error("last flag does not match verdict flag");

    // Order entries appear only in safe runs.
    a_entry_safe: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.is_verdict) |-> out_data.safe)
        else $error("order entry marked unsafe");

    // Results are produced only while a run is in progress.
    a_out_during_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result produced outside a run");

endmodule
